/* design/phn_pkg.sv */
// Shared types and constants of the projection histogram normalizer.
package phn_pkg;

   localparam int BIN_SLOTS  = 64;
   localparam int BIN_W      = 6;
   localparam int COUNT_W    = 7;
   localparam int NBINS_W    = 7;
   localparam int SHARE_W    = 17;
   localparam int PIXEL_W    = 8;
   localparam int CSR_W      = 7;
   localparam int CSR_IDX_W  = 2;

   localparam logic [COUNT_W-1:0] COUNT_TOP  = 7'd127;
   localparam logic [NBINS_W-1:0] SIZE_RESET = 7'd64;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam int DIV_STEPS  = 17;
   localparam int DIV_STEP_W = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS      = 2'd0,
      CSR_COLS      = 2'd1,
      CSR_DIRECTION = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [NBINS_W-1:0] rows;
      logic [NBINS_W-1:0] cols;
      logic               direction;
   } cfg_type;

   // one classified pixel, as queued between front and back
   typedef struct packed {
      logic [BIN_W-1:0]   bin;
      logic               hit;
      logic               last;
      logic [NBINS_W-1:0] nbins;
   } word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   typedef struct packed {
      logic               start;
      logic [COUNT_W-1:0] num;
      logic [COUNT_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [SHARE_W-1:0] quot;
   } div_rsp_type;

endpackage

/* design/phn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module phn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/phn_divider.sv */
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / den) for num <= den.
module phn_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  phn_pkg::div_req_type req,
   output phn_pkg::div_rsp_type rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [phn_pkg::DIV_STEP_W-1:0]  step_ff, step_in;
   logic [phn_pkg::COUNT_W:0]       rem_ff, rem_in;
   logic [phn_pkg::COUNT_W-1:0]     den_ff, den_in;
   logic [phn_pkg::SHARE_W-1:0]     quot_ff, quot_in;
   logic [phn_pkg::COUNT_W:0]       trial;
   logic [phn_pkg::COUNT_W:0]       den_wide;
   logic                            ge;

   always_comb begin
      den_wide = {1'b0, den_ff};
      // first step takes the integer bit, later ones shift in a zero
      trial    = (step_ff == '0) ? rem_ff : {rem_ff[phn_pkg::COUNT_W-1:0], 1'b0};
      ge       = (trial >= den_wide);

      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;

      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = {1'b0, req.num};
         den_in  = req.den;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? (trial - den_wide) : trial;
         quot_in = {quot_ff[phn_pkg::SHARE_W-2:0], ge};
         step_in = step_ff + phn_pkg::DIV_STEP_W'(1);
         if (step_ff == phn_pkg::DIV_STEP_W'(phn_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

/* design/phn_fifo.sv */
// Short word queue between the front and the back.
module phn_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  phn_pkg::word_type        push_word,
   input  logic                     pop,
   output phn_pkg::word_type        head_word,
   output phn_pkg::fifo_status_type status
);

   phn_pkg::word_type               entry_ff [phn_pkg::FIFO_DEPTH];
   logic [phn_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [phn_pkg::FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [phn_pkg::FIFO_CNT_W-1:0]  count_ff, count_in;
   logic                            do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == phn_pkg::FIFO_CNT_W'(phn_pkg::FIFO_DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = do_push ? wr_ptr_ff + phn_pkg::FIFO_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in    = do_pop ? rd_ptr_ff + phn_pkg::FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in     = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + phn_pkg::FIFO_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - phn_pkg::FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign head_word = entry_ff[rd_ptr_ff];

endmodule

/* design/phn_front.sv */
// Front end: accepts pixels, tracks the raster position and classifies each pixel.
module phn_front #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [phn_pkg::PIXEL_W-1:0] req_pixel,
   input  phn_pkg::cfg_type            cfg,
   input  logic                        fifo_full,
   input  logic                        frame_done,
   output logic                        busy,
   output logic                        push,
   output phn_pkg::word_type           word
);

   localparam int ROW_TOP = (MAX_ROWS < phn_pkg::BIN_SLOTS) ? MAX_ROWS : phn_pkg::BIN_SLOTS;
   localparam int COL_TOP = (MAX_COLS < phn_pkg::BIN_SLOTS) ? MAX_COLS : phn_pkg::BIN_SLOTS;
   localparam logic [phn_pkg::NBINS_W-1:0] ROW_LIMIT = phn_pkg::NBINS_W'(ROW_TOP);
   localparam logic [phn_pkg::NBINS_W-1:0] COL_LIMIT = phn_pkg::NBINS_W'(COL_TOP);

   function automatic logic [phn_pkg::NBINS_W-1:0] clamp_size(
      input logic [phn_pkg::NBINS_W-1:0] v,
      input logic [phn_pkg::NBINS_W-1:0] limit
   );
      logic [phn_pkg::NBINS_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = phn_pkg::NBINS_W'(1);
      end else if (v > limit) begin
         r = limit;
      end
      return r;
   endfunction

   logic [phn_pkg::BIN_W-1:0]   row_ff, row_in;
   logic [phn_pkg::BIN_W-1:0]   col_ff, col_in;
   logic                        wait_ff, wait_in;
   logic [phn_pkg::NBINS_W-1:0] rows, cols;
   logic                        col_end, row_end;
   logic                        accept;

   always_comb begin
      rows    = clamp_size(cfg.rows, ROW_LIMIT);
      cols    = clamp_size(cfg.cols, COL_LIMIT);
      busy    = wait_ff || fifo_full;
      accept  = start && !busy;
      // a position at or past a shrunk size ends its line
      col_end = ({1'b0, col_ff} + phn_pkg::NBINS_W'(1)) >= cols;
      row_end = ({1'b0, row_ff} + phn_pkg::NBINS_W'(1)) >= rows;

      word.bin   = cfg.direction ? row_ff : col_ff;
      word.hit   = (req_pixel != '0);
      word.last  = col_end && row_end;
      word.nbins = cfg.direction ? rows : cols;
      push       = accept;

      row_in  = row_ff;
      col_in  = col_ff;
      wait_in = wait_ff;
      if (accept) begin
         if (!col_end) begin
            col_in = col_ff + phn_pkg::BIN_W'(1);
         end else begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + phn_pkg::BIN_W'(1);
            if (row_end) begin
               wait_in = 1'b1;
            end
         end
      end
      if (frame_done) begin
         wait_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         wait_ff <= 1'b0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         wait_ff <= wait_in;
      end
   end

endmodule

/* design/phn_back.sv */
// Back end: bin count update, maximum scan and per-bin normalized output.
module phn_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fifo_empty,
   input  phn_pkg::word_type           head_word,
   output logic                        pop,
   output logic                        frame_done,
   output logic                        rsp_valid,
   output logic [phn_pkg::BIN_W-1:0]   rsp_bin_index,
   output logic [phn_pkg::SHARE_W-1:0] rsp_share,
   output logic                        rsp_last_bin
);

   typedef enum logic [4:0] {
      ST_COUNT  = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_READ   = 5'b00100,
      ST_FETCH  = 5'b01000,
      ST_DIVIDE = 5'b10000
   } back_state_type;

   back_state_type                 state_ff, state_in;
   logic                           b_vld_ff, b_vld_in;
   phn_pkg::word_type              b_word_ff, b_word_in;
   logic                           wr_vld_ff, wr_vld_in;
   logic [phn_pkg::BIN_W-1:0]      wr_bin_ff, wr_bin_in;
   logic [phn_pkg::COUNT_W-1:0]    wr_val_ff, wr_val_in;
   logic [phn_pkg::BIN_SLOTS-1:0]  valid_ff, valid_in;
   logic [phn_pkg::NBINS_W-1:0]    nbins_ff, nbins_in;
   logic [phn_pkg::NBINS_W-1:0]    issue_ff, issue_in;
   logic                           pend_ff, pend_in;
   logic [phn_pkg::BIN_W-1:0]      pend_bin_ff, pend_bin_in;
   logic [phn_pkg::COUNT_W-1:0]    max_ff, max_in;
   logic [phn_pkg::BIN_W-1:0]      k_ff, k_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [phn_pkg::BIN_W-1:0]      rsp_bin_ff, rsp_bin_in;
   logic [phn_pkg::SHARE_W-1:0]    rsp_share_ff, rsp_share_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           ram_we;
   logic [phn_pkg::BIN_W-1:0]      ram_waddr, ram_raddr;
   logic [phn_pkg::COUNT_W-1:0]    ram_wdata, ram_rdata;
   logic [phn_pkg::COUNT_W-1:0]    b_cnt, scan_cnt, fetch_cnt;
   logic                           do_write, bin_last, emit;
   logic [phn_pkg::SHARE_W-1:0]    emit_share;
   phn_pkg::div_req_type           div_req;
   phn_pkg::div_rsp_type           div_rsp;

   phn_ram #(
      .WIDTH (phn_pkg::COUNT_W),
      .DEPTH (phn_pkg::BIN_SLOTS)
   ) u_counts (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   phn_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      pop = (state_ff == ST_COUNT) && !fifo_empty && !(b_vld_ff && b_word_ff.last);

      // the previous word's write lands with this read, so take it from the bypass
      if (wr_vld_ff && (wr_bin_ff == b_word_ff.bin)) begin
         b_cnt = wr_val_ff;
      end else begin
         b_cnt = valid_ff[b_word_ff.bin] ? ram_rdata : '0;
      end
      scan_cnt  = valid_ff[pend_bin_ff] ? ram_rdata : '0;
      fetch_cnt = valid_ff[k_ff] ? ram_rdata : '0;

      do_write  = b_vld_ff && b_word_ff.hit && (b_cnt != phn_pkg::COUNT_TOP);
      ram_we    = do_write;
      ram_waddr = b_word_ff.bin;
      ram_wdata = b_cnt + phn_pkg::COUNT_W'(1);

      unique case (state_ff)
         ST_COUNT: ram_raddr = head_word.bin;
         ST_SCAN:  ram_raddr = issue_ff[phn_pkg::BIN_W-1:0];
         default:  ram_raddr = k_ff;
      endcase

      b_vld_in  = pop;
      b_word_in = pop ? head_word : b_word_ff;
      wr_vld_in = do_write;
      wr_bin_in = b_word_ff.bin;
      wr_val_in = ram_wdata;

      valid_in = valid_ff;
      if (do_write) begin
         valid_in[b_word_ff.bin] = 1'b1;
      end

      bin_last = ({1'b0, k_ff} + phn_pkg::NBINS_W'(1)) == nbins_ff;

      state_in     = state_ff;
      nbins_in     = nbins_ff;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_bin_in  = pend_bin_ff;
      max_in       = max_ff;
      k_in         = k_ff;
      emit         = 1'b0;
      emit_share   = '0;
      div_req      = '0;
      frame_done   = 1'b0;

      unique case (state_ff)
         ST_COUNT: begin
            if (b_vld_ff && b_word_ff.last) begin
               state_in = ST_SCAN;
               nbins_in = b_word_ff.nbins;
               issue_in = '0;
               pend_in  = 1'b0;
               max_in   = '0;
            end
         end
         ST_SCAN: begin
            if (pend_ff && (scan_cnt > max_ff)) begin
               max_in = scan_cnt;
            end
            if (issue_ff < nbins_ff) begin
               pend_in     = 1'b1;
               pend_bin_in = issue_ff[phn_pkg::BIN_W-1:0];
               issue_in    = issue_ff + phn_pkg::NBINS_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_READ;
                  k_in     = '0;
               end
            end
         end
         ST_READ: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            if (max_ff == '0) begin
               emit = 1'b1;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = fetch_cnt;
               div_req.den   = max_ff;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               emit       = 1'b1;
               emit_share = div_rsp.quot;
            end
         end
         default: begin
            state_in = ST_COUNT;
         end
      endcase

      rsp_valid_in = emit;
      rsp_bin_in   = k_ff;
      rsp_share_in = emit_share;
      rsp_last_in  = bin_last;
      if (emit) begin
         if (bin_last) begin
            state_in   = ST_COUNT;
            valid_in   = '0;
            frame_done = 1'b1;
         end else begin
            state_in = ST_READ;
            k_in     = k_ff + phn_pkg::BIN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COUNT;
         b_vld_ff     <= 1'b0;
         wr_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         b_vld_ff     <= b_vld_in;
         wr_vld_ff    <= wr_vld_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      b_word_ff    <= b_word_in;
      wr_bin_ff    <= wr_bin_in;
      wr_val_ff    <= wr_val_in;
      nbins_ff     <= nbins_in;
      issue_ff     <= issue_in;
      pend_ff      <= pend_in;
      pend_bin_ff  <= pend_bin_in;
      max_ff       <= max_in;
      k_ff         <= k_in;
      rsp_bin_ff   <= rsp_bin_in;
      rsp_share_ff <= rsp_share_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bin_index = rsp_bin_ff;
   assign rsp_share     = rsp_share_ff;
   assign rsp_last_bin  = rsp_last_ff;

endmodule

/* design/projection_histogram_normalizer.sv */
// Projection profile histogram: counts nonzero pixels per row or column, then
// emits each bin normalized to the largest count as unsigned Q1.16.
//
// Pixels enter on req_pixel, one word per cycle, when start is high and busy
// is low, in raster order over a frame of rows x columns set through the csr_
// write port (rows, columns, direction). Mid-frame pixels give no result.
// Pixel words pass through a four-word queue into a read-modify-write bin
// counter that takes one word per cycle, so the frame streams at one pixel a
// cycle. After the frame's last pixel busy stays high: the counts are scanned
// for the maximum, then each bin is read and, unless the maximum is zero,
// divided by a one-bit-per-cycle divider; when every count is zero, each
// share is zero and no division is done. Each result is shown for one
// cycle with rsp_valid; rsp_last_bin marks the final bin, and busy drops in
// that cycle so the next frame can start at once. The receiver cannot stall.
// Reset clears the positions, the queue and the count valid bits (so all bins
// read as zero); configuration returns to 64 x 64, column direction.
module projection_histogram_normalizer #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [phn_pkg::PIXEL_W-1:0]   req_pixel,
   output logic                          rsp_valid,
   output logic [phn_pkg::BIN_W-1:0]     rsp_bin_index,
   output logic [phn_pkg::SHARE_W-1:0]   rsp_share,
   output logic                          rsp_last_bin,
   input  logic                          csr_we,
   input  logic [phn_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [phn_pkg::CSR_W-1:0]     csr_wdata
);

   phn_pkg::cfg_type         cfg_ff, cfg_in;
   phn_pkg::word_type        front_word, head_word;
   phn_pkg::fifo_status_type fifo_status;
   logic                     push, pop, frame_done;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (phn_pkg::csr_index_type'(csr_index))
            phn_pkg::CSR_ROWS:      cfg_in.rows      = csr_wdata;
            phn_pkg::CSR_COLS:      cfg_in.cols      = csr_wdata;
            phn_pkg::CSR_DIRECTION: cfg_in.direction = csr_wdata[0];
            default:                cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows      <= phn_pkg::SIZE_RESET;
         cfg_ff.cols      <= phn_pkg::SIZE_RESET;
         cfg_ff.direction <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   phn_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_pixel  (req_pixel),
      .cfg        (cfg_ff),
      .fifo_full  (fifo_status.full),
      .frame_done (frame_done),
      .busy       (busy),
      .push       (push),
      .word       (front_word)
   );

   phn_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (front_word),
      .pop       (pop),
      .head_word (head_word),
      .status    (fifo_status)
   );

   phn_back u_back (
      .clock         (clock),
      .reset         (reset),
      .fifo_empty    (fifo_status.empty),
      .head_word     (head_word),
      .pop           (pop),
      .frame_done    (frame_done),
      .rsp_valid     (rsp_valid),
      .rsp_bin_index (rsp_bin_index),
      .rsp_share     (rsp_share),
      .rsp_last_bin  (rsp_last_bin)
   );

endmodule

/* design/phn_checker.sv */
// Port-level checks of the projection histogram normalizer, bound to the top level.
module phn_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic                        rsp_valid,
   input logic [phn_pkg::SHARE_W-1:0] rsp_share,
   input logic                        rsp_last_bin
);

   localparam logic [phn_pkg::SHARE_W-1:0] ONE_Q16 = 17'h10000;

   // a share can never exceed 1.0 since the divisor is the maximum count
   a_share_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_share <= ONE_Q16))
      else $error("share above 1.0");

   // the block stays busy while bins other than the final one are emitted
   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_bin) |-> busy)
      else $error("not busy during bin output");

   // each bin passes through the read and fetch states, so results never come back to back
   a_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results on consecutive cycles");

   // bins run in order: a non-final bin is followed by more busy time
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_bin) |=> busy)
      else $error("busy dropped before the final bin");

   // no result may come out in the cycle a pixel is accepted mid-frame
   a_no_emit_on_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> (!rsp_valid || rsp_last_bin))
      else $error("result during pixel intake");

endmodule

bind projection_histogram_normalizer phn_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_share     (rsp_share),
   .rsp_last_bin  (rsp_last_bin)
);
